>>> rtl/msld_pkg.sv
// ----------------------------------------------------------------------------
// msld_pkg
// Shared types and constants of the motor slew limiter with dead-zone skip.
// ----------------------------------------------------------------------------
package msld_pkg;

    localparam int CHANNELS = 4;

    localparam int CH_W    = 2;
    localparam int DRV_W   = 8;
    localparam int CFG_W   = 7;
    localparam int CIDX_W  = 3;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    localparam logic [CIDX_W-1:0] REG_DZ_LOW  = 3'd0;
    localparam logic [CIDX_W-1:0] REG_DZ_HIGH = 3'd1;
    localparam logic [CIDX_W-1:0] REG_SLEW0   = 3'd2;
    localparam logic [CIDX_W-1:0] REG_SLEW3   = 3'd5;

    localparam logic [CFG_W-1:0] DZ_LOW_RST  = 7'd10;
    localparam logic [CFG_W-1:0] DZ_HIGH_RST = 7'd90;
    localparam logic [CFG_W-1:0] SLEW_RST    = 7'd15;

    localparam logic signed [DRV_W-1:0] DRV_MAX = 8'sd127;
    localparam logic signed [DRV_W-1:0] DRV_MIN = -8'sd127;
    localparam logic signed [DRV_W-1:0] DRV_RAW_MIN = -8'sd128;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_BAIL  = 2'd2;
    localparam logic [1:0] KIND_NOP   = 2'd3;

    typedef struct packed {
        logic [1:0]                kind;
        logic [CH_W-1:0]           channel;
        logic signed [DRV_W-1:0]   target;
    } item_t;

    typedef struct packed {
        logic [CH_W-1:0]           channel;
        logic signed [DRV_W-1:0]   drive;
        logic                      last;
    } result_t;

endpackage

>>> rtl/motor_slew_limiter_deadzone.sv
// ----------------------------------------------------------------------------
// motor_slew_limiter_deadzone
// Multi-channel motor drive slew limiter with dead-zone skipping.
//
//   channel   direction  handshake      payload
//   request   in         push / full    req_type, channel, target, bailout
//   result    out        pop / empty    channel_res, drive, last
//   config    in         cfg_wr         cfg_index, cfg_data
//
// A write item is applied as the engine takes it; a tick steps one channel
// per cycle through the single step unit while the result queue has room.
// A two-entry item queue separates intake from the engine; a two-entry
// result queue lets the engine stall on pop without losing results.
// Reset zeroes drives and targets, empties both queues, loads register
// defaults.
// ----------------------------------------------------------------------------
module motor_slew_limiter_deadzone (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              req_type,
    input  logic [msld_pkg::CH_W-1:0]         channel,
    input  logic signed [msld_pkg::DRV_W-1:0] target,
    input  logic                              bailout,
    output logic                              empty,
    input  logic                              pop,
    output logic [msld_pkg::CH_W-1:0]         channel_res,
    output logic signed [msld_pkg::DRV_W-1:0] drive,
    output logic                              last,
    input  logic                              cfg_wr,
    input  logic [msld_pkg::CIDX_W-1:0]       cfg_index,
    input  logic [msld_pkg::CFG_W-1:0]        cfg_data
);
    import msld_pkg::*;

    logic    item_valid;
    logic    item_pop;
    item_t   item;
    result_t res;

    msld_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .req_type   (req_type),
        .channel    (channel),
        .target     (target),
        .bailout    (bailout),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    msld_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr     (cfg_wr),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .empty      (empty),
        .pop        (pop),
        .res        (res)
    );

    assign channel_res = res.channel;
    assign drive       = res.drive;
    assign last        = res.last;

endmodule

>>> rtl/msld_front.sv
// ----------------------------------------------------------------------------
// msld_front
// Accepts items, classifies them and saturates targets, queues them for the
// stepping engine.
// ----------------------------------------------------------------------------
module msld_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          req_type,
    input  logic [msld_pkg::CH_W-1:0]     channel,
    input  logic signed [msld_pkg::DRV_W-1:0] target,
    input  logic                          bailout,
    output logic                          item_valid,
    output msld_pkg::item_t               item,
    input  logic                          item_pop
);
    import msld_pkg::*;

    item_t               q_mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_push, do_pop;
    item_t               cls;

    assign full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign item_valid = (cnt_reg != '0);
    assign item       = q_mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_pop && item_valid;

    always_comb
    begin
        cls.channel = channel;
        cls.target  = (target == DRV_RAW_MIN) ? DRV_MIN : target;
        if (req_type)
        begin
            cls.kind = bailout ? KIND_BAIL : KIND_TICK;
        end
        else if (32'(channel) < CHANNELS)
        begin
            cls.kind = KIND_WRITE;
        end
        else
        begin
            cls.kind = KIND_NOP;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QDEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QDEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

>>> rtl/msld_back.sv
// ----------------------------------------------------------------------------
// msld_back
// Holds drive and target state and the configuration, steps one channel per
// cycle on a tick while the result queue has room, and queues the channel results.
// ----------------------------------------------------------------------------
module msld_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr,
    input  logic [msld_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [msld_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          item_valid,
    input  msld_pkg::item_t               item,
    output logic                          item_pop,
    output logic                          empty,
    input  logic                          pop,
    output msld_pkg::result_t             res
);
    import msld_pkg::*;

    logic signed [DRV_W-1:0] drive_reg  [CHANNELS];
    logic signed [DRV_W-1:0] target_reg [CHANNELS];
    logic [CFG_W-1:0]        slew_reg   [CHANNELS];
    logic [CFG_W-1:0]        dz_low_reg;
    logic [CFG_W-1:0]        dz_high_reg;

    logic                    active_reg, active_next;
    logic                    bail_reg, bail_next;
    logic [CH_W-1:0]         ch_cnt_reg, ch_cnt_next;

    result_t                 oq_mem [QDEPTH];
    logic [QPTR_W-1:0]       oq_wr_reg, oq_wr_next;
    logic [QPTR_W-1:0]       oq_rd_reg, oq_rd_next;
    logic [QCNT_W-1:0]       oq_cnt_reg, oq_cnt_next;
    logic                    oq_full, oq_push, oq_pop;

    logic                    step_en, last_ch;
    logic signed [DRV_W-1:0] new_drive;
    result_t                 new_res;

    function automatic logic signed [DRV_W-1:0] step_one(
        input logic signed [DRV_W-1:0] x_in,
        input logic signed [DRV_W-1:0] t_in,
        input logic [CFG_W-1:0]        s_in,
        input logic [CFG_W-1:0]        lo_in,
        input logic [CFG_W-1:0]        hi_in
    );
        logic signed [9:0] x, t, s, lo, hi, y, r;
        x  = 10'(x_in);
        t  = 10'(t_in);
        s  = signed'({3'b000, s_in});
        lo = signed'({3'b000, lo_in});
        hi = signed'({3'b000, hi_in});
        if (t == x)
        begin
            r = x;
        end
        else if (t > x)
        begin
            if (x < -hi)
            begin
                x = -hi;
            end
            else if (x >= -lo && x <= lo)
            begin
                x = lo;
            end
            else if (x > hi)
            begin
                x = 10'(DRV_MAX);
            end
            y = x + s;
            r = (t < y) ? t : y;
        end
        else
        begin
            if (x < -hi)
            begin
                x = 10'(DRV_MIN);
            end
            else if (x >= -lo && x <= lo)
            begin
                x = -lo;
            end
            else if (x > hi)
            begin
                x = hi;
            end
            y = x - s;
            r = (t > y) ? t : y;
        end
        return r[DRV_W-1:0];
    endfunction

    assign oq_full  = (oq_cnt_reg == QCNT_W'(QDEPTH));
    assign empty    = (oq_cnt_reg == '0);
    assign res      = oq_mem[oq_rd_reg];
    assign oq_pop   = pop && !empty;

    assign item_pop = !active_reg && item_valid;
    assign step_en  = active_reg && !oq_full;
    assign oq_push  = step_en;
    assign last_ch  = (32'(ch_cnt_reg) == CHANNELS - 1);

    assign new_drive = bail_reg ? '0 :
        step_one(drive_reg[ch_cnt_reg], target_reg[ch_cnt_reg], slew_reg[ch_cnt_reg],
                 dz_low_reg, dz_high_reg);

    always_comb
    begin
        new_res.channel = ch_cnt_reg;
        new_res.drive   = new_drive;
        new_res.last    = last_ch;
    end

    always_comb
    begin
        active_next = active_reg;
        bail_next   = bail_reg;
        ch_cnt_next = ch_cnt_reg;
        if (item_pop)
        begin
            if (item.kind == KIND_TICK || item.kind == KIND_BAIL)
            begin
                active_next = 1'b1;
                bail_next   = (item.kind == KIND_BAIL);
                ch_cnt_next = '0;
            end
        end
        else if (step_en)
        begin
            if (last_ch)
            begin
                active_next = 1'b0;
                ch_cnt_next = '0;
            end
            else
            begin
                ch_cnt_next = ch_cnt_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        oq_wr_next  = oq_wr_reg;
        oq_rd_next  = oq_rd_reg;
        oq_cnt_next = oq_cnt_reg;
        if (oq_push)
        begin
            oq_wr_next = (32'(oq_wr_reg) == QDEPTH - 1) ? '0 : oq_wr_reg + 1'b1;
        end
        if (oq_pop)
        begin
            oq_rd_next = (32'(oq_rd_reg) == QDEPTH - 1) ? '0 : oq_rd_reg + 1'b1;
        end
        if (oq_push && !oq_pop)
        begin
            oq_cnt_next = oq_cnt_reg + 1'b1;
        end
        else if (!oq_push && oq_pop)
        begin
            oq_cnt_next = oq_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            bail_reg    <= 1'b0;
            ch_cnt_reg  <= '0;
            oq_wr_reg   <= '0;
            oq_rd_reg   <= '0;
            oq_cnt_reg  <= '0;
            dz_low_reg  <= DZ_LOW_RST;
            dz_high_reg <= DZ_HIGH_RST;
            for (int i = 0; i < CHANNELS; i++)
            begin
                drive_reg[i]  <= '0;
                target_reg[i] <= '0;
                slew_reg[i]   <= SLEW_RST;
            end
        end
        else
        begin
            active_reg <= active_next;
            bail_reg   <= bail_next;
            ch_cnt_reg <= ch_cnt_next;
            oq_wr_reg  <= oq_wr_next;
            oq_rd_reg  <= oq_rd_next;
            oq_cnt_reg <= oq_cnt_next;
            if (cfg_wr)
            begin
                if (cfg_index == REG_DZ_LOW)
                begin
                    dz_low_reg <= cfg_data;
                end
                else if (cfg_index == REG_DZ_HIGH)
                begin
                    dz_high_reg <= cfg_data;
                end
                else if (cfg_index >= REG_SLEW0 && cfg_index <= REG_SLEW3)
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        if (cfg_index == REG_SLEW0 + CIDX_W'(i))
                        begin
                            slew_reg[i] <= cfg_data;
                        end
                    end
                end
            end
            if (item_pop && item.kind == KIND_WRITE)
            begin
                target_reg[item.channel] <= item.target;
            end
            if (step_en)
            begin
                drive_reg[ch_cnt_reg] <= new_drive;
                if (bail_reg)
                begin
                    target_reg[ch_cnt_reg] <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_mem[oq_wr_reg] <= new_res;
        end
    end

    a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        oq_cnt_reg <= QCNT_W'(QDEPTH))
        else $error("result queue count out of range");

    a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> ch_cnt_reg == '0)
        else $error("channel counter moved while idle");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && last_ch |=> !active_reg)
        else $error("tick did not end after final channel");

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for motor_slew_limiter_deadzone. Target writes and ticks
// are pushed in with random gaps. Drive results are popped with random stalls
// and compared against an in-bench model of the slew and dead-zone rules.
// The register settings cover the extremes and an inverted dead zone. The
// bench also runs a long pop hold-off that backs up the input, and a full
// drain in the middle of a phase.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import msld_pkg::*;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_TICK  = 1'b1;
    localparam int   QUIET     = 12;

    class slew_scoreboard;
        logic signed [DRV_W-1:0] drive_now  [CHANNELS];
        logic signed [DRV_W-1:0] drive_goal [CHANNELS];
        logic [CFG_W-1:0]        dz_low;
        logic [CFG_W-1:0]        dz_high;
        logic [CFG_W-1:0]        slew [CHANNELS];
        result_t                 expected_q [$];
        int                      mismatches;
        int                      compared;
        int                      writes;
        int                      ticks;
        int                      bails;

        function new();
            for (int i = 0; i < CHANNELS; i++)
            begin
                drive_now[i]  = '0;
                drive_goal[i] = '0;
                slew[i]       = SLEW_RST;
            end
            dz_low     = DZ_LOW_RST;
            dz_high    = DZ_HIGH_RST;
            mismatches = 0;
            compared   = 0;
            writes     = 0;
            ticks      = 0;
            bails      = 0;
        endfunction

        function void set_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_DZ_LOW)
                dz_low = val;
            else if (idx == REG_DZ_HIGH)
                dz_high = val;
            else if (idx >= REG_SLEW0 && idx <= REG_SLEW3)
                slew[CH_W'(idx - REG_SLEW0)] = val;
        endfunction

        // one slew move, with the jump across a dead zone first
        function logic signed [DRV_W-1:0] step_drive(logic signed [DRV_W-1:0] cur,
                                                     logic signed [DRV_W-1:0] goal,
                                                     logic [CFG_W-1:0] stp);
            int x;
            int t;
            int lo;
            int hi;
            int s;
            int r;
            x  = int'(cur);
            t  = int'(goal);
            lo = int'(dz_low);
            hi = int'(dz_high);
            s  = int'(stp);
            if (t == x)
                r = x;
            else if (t > x)
            begin
                if (x < -hi)
                    x = -hi;
                else if (x >= -lo && x <= lo)
                    x = lo;
                else if (x > hi)
                    x = 127;
                x = x + s;
                r = (t < x) ? t : x;
            end
            else
            begin
                if (x < -hi)
                    x = -127;
                else if (x >= -lo && x <= lo)
                    x = -lo;
                else if (x > hi)
                    x = hi;
                x = x - s;
                r = (t > x) ? t : x;
            end
            return r[DRV_W-1:0];
        endfunction

        function void note_item(logic rtype, logic [CH_W-1:0] ch,
                                logic signed [DRV_W-1:0] tgt, logic bail);
            result_t r;
            if (rtype == REQ_WRITE)
            begin
                writes++;
                drive_goal[ch] = (tgt == DRV_RAW_MIN) ? DRV_MIN : tgt;
            end
            else
            begin
                ticks++;
                if (bail)
                    bails++;
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (bail)
                    begin
                        drive_now[i]  = '0;
                        drive_goal[i] = '0;
                    end
                    else
                        drive_now[i] = step_drive(drive_now[i], drive_goal[i], slew[i]);
                    r.channel = i[CH_W-1:0];
                    r.drive   = drive_now[i];
                    r.last    = (i == CHANNELS - 1);
                    expected_q.push_back(r);
                end
            end
        endfunction

        function void complain(string field, int exp_v, int act_v);
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, exp_v, act_v);
        endfunction

        function void check_result(logic [CH_W-1:0] ch, logic signed [DRV_W-1:0] drv,
                                   logic lst);
            result_t e;
            compared++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual ch %0d",
                         $time, ch);
                $display("%0t:   drive %0d last %0d", $time, drv, lst);
                return;
            end
            e = expected_q.pop_front();
            if (ch !== e.channel)
                complain("channel_res", int'(e.channel), int'(ch));
            if (drv !== e.drive)
                complain("drive", int'(e.drive), int'(drv));
            if (lst !== e.last)
                complain("last", int'(e.last), int'(lst));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    push      = 1'b0;
    logic                    full;
    logic                    req_type  = 1'b0;
    logic [CH_W-1:0]         channel   = '0;
    logic signed [DRV_W-1:0] target    = '0;
    logic                    bailout   = 1'b0;
    logic                    empty;
    logic                    pop       = 1'b0;
    logic [CH_W-1:0]         channel_res;
    logic signed [DRV_W-1:0] drive;
    logic                    last;
    logic                    cfg_wr    = 1'b0;
    logic [CIDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]        cfg_data  = '0;

    slew_scoreboard sb = new();
    int tx_idle_pct = 38;
    int rx_idle_pct = 38;
    int hold_cycles = 0;
    int settings    = 0;

    motor_slew_limiter_deadzone u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .channel     (channel),
        .target      (target),
        .bailout     (bailout),
        .empty       (empty),
        .pop         (pop),
        .channel_res (channel_res),
        .drive       (drive),
        .last        (last),
        .cfg_wr      (cfg_wr),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // result side: check on each pop, then pick next pop
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (pop === 1'b1 && empty === 1'b0)
                sb.check_result(channel_res, drive, last);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task send_item(input logic rtype, input logic [CH_W-1:0] ch,
                   input logic signed [DRV_W-1:0] tgt, input logic bail);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push     <= 1'b1;
        req_type <= rtype;
        channel  <= ch;
        target   <= tgt;
        bailout  <= bail;
        do @(posedge clk); while (full !== 1'b0);
        sb.note_item(rtype, ch, tgt, bail);
    endtask

    task wait_drained();
        push <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task cfg_put(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task configure(input int lo, input int hi, input int s0, input int s1,
                   input int s2, input int s3);
        wait_drained();
        repeat (QUIET) @(posedge clk);
        cfg_put(REG_DZ_LOW, CFG_W'(lo));
        cfg_put(REG_DZ_HIGH, CFG_W'(hi));
        cfg_put(REG_SLEW0, CFG_W'(s0));
        cfg_put(REG_SLEW0 + 3'd1, CFG_W'(s1));
        cfg_put(REG_SLEW0 + 3'd2, CFG_W'(s2));
        cfg_put(REG_SLEW3, CFG_W'(s3));
        cfg_wr <= 1'b0;
        @(posedge clk);
        settings++;
    endtask

    // targets lean toward the range ends and the dead-zone edges
    function automatic logic signed [DRV_W-1:0] pick_target();
        int lo;
        int hi;
        int v;
        lo = int'(sb.dz_low);
        hi = int'(sb.dz_high);
        if ($urandom_range(2) != 0)
            v = int'($urandom_range(255));
        else
            case ($urandom_range(9))
                0: v = 127;
                1: v = -128;
                2: v = -127;
                3: v = 0;
                4: v = lo;
                5: v = -lo;
                6: v = hi;
                7: v = -hi;
                8: v = hi + 1;
                default: v = -(hi + 1);
            endcase
        return v[DRV_W-1:0];
    endfunction

    task rand_item();
        logic signed [DRV_W-1:0] t;
        logic [CH_W-1:0]         ch;
        t  = pick_target();
        ch = CH_W'($urandom_range(CHANNELS - 1));
        if ($urandom_range(99) < 50)
            send_item(REQ_WRITE, ch, t, 1'($urandom_range(1)));
        else
            send_item(REQ_TICK, ch, t, $urandom_range(99) < 6);
    endtask

    task run_items(input int n);
        repeat (n) rand_item();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults; saturation, bailout on a write, zone jumps
        send_item(REQ_WRITE, 2'd0, 8'sd127, 1'b0);
        send_item(REQ_WRITE, 2'd1, -8'sd128, 1'b1);
        send_item(REQ_WRITE, 2'd2, 8'sd50, 1'b0);
        send_item(REQ_WRITE, 2'd3, -8'sd5, 1'b0);
        send_item(REQ_TICK, 2'd0, 8'sd0, 1'b0);
        send_item(REQ_TICK, 2'd3, 8'sd85, 1'b0);
        send_item(REQ_TICK, 2'd1, -8'sd42, 1'b0);
        send_item(REQ_WRITE, 2'd2, -8'sd60, 1'b0);
        send_item(REQ_WRITE, 2'd3, 8'sd100, 1'b0);
        send_item(REQ_TICK, 2'd2, 8'sd0, 1'b0);
        send_item(REQ_TICK, 2'd0, 8'sd0, 1'b0);
        send_item(REQ_TICK, 2'd3, -8'sd1, 1'b1);
        send_item(REQ_WRITE, 2'd0, 8'sd0, 1'b1);
        send_item(REQ_TICK, 2'd0, 8'sd0, 1'b0);
        send_item(REQ_WRITE, 2'd1, 8'sd95, 1'b0);
        send_item(REQ_WRITE, 2'd0, -8'sd100, 1'b0);
        send_item(REQ_TICK, 2'd1, 8'sd0, 1'b0);
        send_item(REQ_TICK, 2'd0, 8'sd0, 1'b0);
        send_item(REQ_TICK, 2'd0, 8'sd0, 1'b0);
        send_item(REQ_TICK, 2'd2, 8'sd0, 1'b0);

        configure(0, 127, 127, 0, 1, 64);
        run_items(25);

        // inverted dead zone, no gaps on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        configure(126, 1, $urandom_range(127), $urandom_range(127),
                  $urandom_range(127), $urandom_range(127));
        run_items(20);
        tx_idle_pct = 38;
        rx_idle_pct = 38;

        // pop held off while items keep coming, so the input backs up
        configure($urandom_range(126), $urandom_range(127, 1), $urandom_range(127),
                  $urandom_range(127), $urandom_range(127), $urandom_range(127));
        hold_cycles = 80;
        tx_idle_pct = 0;
        run_items(16);
        tx_idle_pct = 38;
        run_items(10);

        configure(10, 90, 15, 15, 15, 15);
        cfg_put(REG_SLEW3 + 3'd1, CFG_W'($urandom_range(127)));
        cfg_put(REG_SLEW3 + 3'd2, CFG_W'($urandom_range(127)));
        cfg_wr <= 1'b0;
        @(posedge clk);
        run_items(12);
        wait_drained();
        run_items(13);

        wait_drained();
        repeat (20) @(posedge clk);

        $display("summary: %0d target writes, %0d ticks (%0d with bailout), %0d settings",
                 sb.writes, sb.ticks, sb.bails, settings);
        $display("summary: %0d drive results compared, %0d mismatches, %0d left waiting",
                 sb.compared, sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
rtl/msld_pkg.sv
rtl/msld_front.sv
rtl/msld_back.sv
rtl/motor_slew_limiter_deadzone.sv
verif/tb.sv
